FILE: src/vlra_pkg.sv
// Shared types, constants and helpers for the variable-length ring allocator.
package vlra_pkg;

    // Width of offsets, lengths and counts inside the allocator.
    localparam int OFS_W = 13;
    // Width of the running reserved-byte total.
    localparam int TOT_W = 32;
    // Default capacity of the ring in bytes.
    localparam int CAPACITY_DEFAULT = 4096;
    // Size register value after reset.
    localparam logic [OFS_W-1:0] SIZE_RESET = OFS_W'(4096);
    // Smallest ring that still makes sense.
    localparam logic [OFS_W-1:0] SIZE_MIN = OFS_W'(2);

    typedef logic [OFS_W-1:0] ofs_t;
    typedef logic [TOT_W-1:0] tot_t;

    typedef enum logic [1:0] {
        ACT_RESERVE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_GET     = 2'd2,
        ACT_REINIT  = 2'd3
    } action_t;

    // Clamp a written size into the range two to capacity.
    function automatic ofs_t eff_size(input ofs_t value, input int capacity);
        ofs_t s;
        s = value;
        if (s < SIZE_MIN) begin
            s = SIZE_MIN;
        end
        if (int'(s) > capacity) begin
            s = OFS_W'(capacity);
        end
        return s;
    endfunction

endpackage

FILE: src/variable_length_ring_allocator.sv
// Offset manager for a byte ring buffer that hands out contiguous regions.
// An accepted item goes through the item register and then the result register; its result
// is then on the result ports, marked by done.
// Throughput: one item per cycle; busy is never raised, as the offset registers are updated
// by a single short compare-and-add stage between the item register and the result register.
// Reset: rst_n clears the state asynchronously; the ring size returns to 4096 bytes clamped to
// CAPACITY, all offsets and counts to zero and the wrap mark to the last offset of the ring.
module variable_length_ring_allocator #(
    parameter int CAPACITY = vlra_pkg::CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [vlra_pkg::OFS_W-1:0]  cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [vlra_pkg::OFS_W-1:0]  length,
    output logic                        done,
    output logic                        ok,
    output logic [vlra_pkg::OFS_W-1:0]  region_offset,
    output logic [vlra_pkg::OFS_W-1:0]  region_length,
    output logic [vlra_pkg::OFS_W-1:0]  used_bytes,
    output logic [vlra_pkg::TOT_W-1:0]  total_reserved
);
    import vlra_pkg::*;

    // Effective ring size after reset.
    localparam ofs_t SIZE_INIT = eff_size(SIZE_RESET, CAPACITY);

    // Item register: holds the accepted item until the allocator state is updated from it.
    logic    item_vld_reg;
    action_t item_act_reg;
    ofs_t    item_len_reg;

    // Allocator state. The size register already holds the clamped size.
    ofs_t size_reg,  size_next;
    ofs_t wr_reg,    wr_next;
    ofs_t rd_reg,    rd_next;
    ofs_t wmark_reg, wmark_next;
    ofs_t used_reg,  used_next;
    tot_t total_reg, total_next;

    // Result register.
    logic done_reg;
    logic ok_reg,   ok_next;
    ofs_t off_reg,  off_next;
    ofs_t rlen_reg, rlen_next;

    ofs_t end_ofs;
    logic [OFS_W:0] used_sum;
    logic [OFS_W:0] wr_sum;
    ofs_t rd_eff;
    ofs_t wmark_eff;
    ofs_t want;
    ofs_t avail;
    ofs_t grant;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= start && !busy;
        end
    end

    // The item payload needs no reset; it is only used when the valid flag is set.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_act_reg <= action_t'(action);
            item_len_reg <= length;
        end
    end

    assign end_ofs = size_reg - OFS_W'(1);

    always_comb
    begin
        size_next  = size_reg;
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        wmark_next = wmark_reg;
        used_next  = used_reg;
        total_next = total_reg;
        ok_next    = 1'b0;
        off_next   = '0;
        rlen_next  = '0;

        used_sum = {1'b0, used_reg} + {1'b0, item_len_reg};
        wr_sum   = {1'b0, wr_reg} + {1'b0, item_len_reg};

        // On a get, a read offset sitting on the wrap mark moves back to the ring start.
        if (wmark_reg == rd_reg)
        begin
            rd_eff    = '0;
            wmark_eff = end_ofs;
        end
        else
        begin
            rd_eff    = rd_reg;
            wmark_eff = wmark_reg;
        end
        want  = (used_reg > item_len_reg) ? item_len_reg : used_reg;
        avail = (wmark_eff >= rd_eff) ? (wmark_eff - rd_eff) : '0;
        grant = (avail >= want) ? want : avail;

        if (cfg_we)
        begin
            // A size write also reinitialises the ring.
            size_next  = eff_size(cfg_wdata, CAPACITY);
            wr_next    = '0;
            rd_next    = '0;
            wmark_next = size_next - OFS_W'(1);
            used_next  = '0;
            total_next = '0;
        end
        else if (item_vld_reg)
        begin
            unique case (item_act_reg)
                ACT_RESERVE:
                begin
                    if (used_sum <= {1'b0, size_reg})
                    begin
                        if (wr_sum <= {1'b0, end_ofs})
                        begin
                            off_next = wr_reg;
                            wr_next  = wr_sum[OFS_W-1:0];
                        end
                        else
                        begin
                            // Tail too short: remember where valid data stops and wrap.
                            wmark_next = wr_reg;
                            off_next   = '0;
                            wr_next    = item_len_reg;
                        end
                        used_next  = used_sum[OFS_W-1:0];
                        total_next = total_reg + TOT_W'(item_len_reg);
                        ok_next    = 1'b1;
                        rlen_next  = item_len_reg;
                    end
                end
                ACT_RELEASE:
                begin
                    used_next = (used_reg > item_len_reg) ? (used_reg - item_len_reg) : '0;
                end
                ACT_GET:
                begin
                    rd_next    = rd_eff;
                    wmark_next = wmark_eff;
                    if (used_reg != '0 && grant != '0)
                    begin
                        ok_next   = 1'b1;
                        off_next  = rd_eff;
                        rlen_next = grant;
                        rd_next   = rd_eff + grant;
                    end
                end
                ACT_REINIT:
                begin
                    wr_next    = '0;
                    rd_next    = '0;
                    wmark_next = end_ofs;
                    used_next  = '0;
                    total_next = '0;
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_INIT;
            wr_reg    <= '0;
            rd_reg    <= '0;
            wmark_reg <= SIZE_INIT - OFS_W'(1);
            used_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            size_reg  <= size_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            wmark_reg <= wmark_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            done_reg  <= item_vld_reg;
        end
    end

    // Result payload is only looked at while done is high.
    always_ff @(posedge clk)
    begin
        if (item_vld_reg)
        begin
            ok_reg   <= ok_next;
            off_reg  <= off_next;
            rlen_reg <= rlen_next;
        end
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign region_offset  = off_reg;
    assign region_length  = rlen_reg;
    // The counts shown are the state left by the item just finished.
    assign used_bytes     = used_reg;
    assign total_reserved = total_reg;

    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_vld_reg |=> done)
        else $error("result strobe missing after an item");

    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= size_reg)
        else $error("used count exceeds ring size");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= size_reg)
        else $error("write offset beyond ring size");

    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (region_offset == '0 && region_length == '0))
        else $error("refused item carries a region");

    a_size_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg >= SIZE_MIN)
        else $error("ring size below minimum");

endmodule
